### sv/nnis_pkg.sv
// Shared types and constants for the nearest-neighbor image scaler.
// No dependencies; imported by the scaler top level and its checker.
package nnis_pkg;

   localparam int COORD_BITS     = 12;
   localparam int SRC_CFG_BITS   = 7;
   localparam int DST_BITS       = 12;
   localparam int MODE_BITS      = 2;
   localparam int WORD_PIX_BITS  = 32;
   localparam int MAPPED_BITS    = 6;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   // frame store geometry
   localparam int MAX_SOURCE_WIDTH  = 64;
   localparam int MAX_SOURCE_HEIGHT = 64;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROUNDING_MODE = 3'd4;

   // opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // rounding modes; the unused code behaves as floor
   localparam logic [MODE_BITS-1:0] RND_FLOOR   = 2'd0;
   localparam logic [MODE_BITS-1:0] RND_NEAREST = 2'd1;
   localparam logic [MODE_BITS-1:0] RND_CEIL    = 2'd2;

   // reset values of the registers
   localparam logic [SRC_CFG_BITS-1:0] RST_SOURCE_SIZE = 7'd64;
   localparam logic [DST_BITS-1:0]     RST_TARGET_SIZE = 12'd64;
   localparam logic [MODE_BITS-1:0]    RST_MODE        = RND_NEAREST;

   typedef struct packed {
      logic                     opcode;
      logic [COORD_BITS-1:0]    coord_x;
      logic [COORD_BITS-1:0]    coord_y;
      logic [WORD_PIX_BITS-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [WORD_PIX_BITS-1:0] pixel_out;
      logic [MAPPED_BITS-1:0]   mapped_x;
      logic [MAPPED_BITS-1:0]   mapped_y;
   } rsp_type;

endpackage

### sv/nearest_neighbor_image_scaler.sv
// Nearest-neighbor image scaler: frame store, pipelined coordinate dividers
// and a single-port pixel memory. Depends on nnis_pkg.
// Pipeline: a fetch word's result strobes after one multiply stage, one divider
// stage per numerator bit, a rounding stage and the memory read.
// Throughput: one word per cycle; busy stays low, the receiver cannot stall.
// Reset clears the registers to their defaults and drops words in flight; the
// frame store keeps its contents.
module nearest_neighbor_image_scaler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  nnis_pkg::req_type                    req_word,
   output logic                                 rsp_strobe,
   output nnis_pkg::rsp_type                    rsp_word,
   input  logic                                 csr_write_en,
   input  logic [nnis_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [nnis_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import nnis_pkg::*;

   localparam int SWX   = $clog2(MAX_SOURCE_WIDTH + 1);
   localparam int SWY   = $clog2(MAX_SOURCE_HEIGHT + 1);
   localparam int SWM   = (SWX > SWY) ? SWX : SWY;
   localparam int XW    = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
   localparam int YW    = (MAX_SOURCE_HEIGHT > 1) ? $clog2(MAX_SOURCE_HEIGHT) : 1;
   localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
   localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIV_BITS = COORD_BITS + SWM;
   localparam int RB    = DST_BITS + 1;

   typedef struct packed {
      logic [DIV_BITS-1:0] nq;    // numerator shifting out, quotient shifting in
      logic [RB-1:0]       rem;
      logic [DST_BITS-1:0] dst;
      logic [SWM-1:0]      src;
   } axis_type;

   typedef struct packed {
      logic                     vld;
      logic                     op;
      logic [MODE_BITS-1:0]     mode;
      logic [WORD_PIX_BITS-1:0] pix;
      logic [AB-1:0]            addr;
      axis_type                 ax_x;
      axis_type                 ax_y;
   } stage_type;

   typedef struct packed {
      logic                     vld;
      logic                     op;
      logic [WORD_PIX_BITS-1:0] pix;
      logic [AB-1:0]            addr;
      logic [XW-1:0]            mx;
      logic [YW-1:0]            my;
   } access_type;

   // configuration registers
   logic [SRC_CFG_BITS-1:0] src_w_ff;
   logic [SRC_CFG_BITS-1:0] src_h_ff;
   logic [DST_BITS-1:0]     dst_w_ff;
   logic [DST_BITS-1:0]     dst_h_ff;
   logic [MODE_BITS-1:0]    mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= RST_SOURCE_SIZE;
         src_h_ff <= RST_SOURCE_SIZE;
         dst_w_ff <= RST_TARGET_SIZE;
         dst_h_ff <= RST_TARGET_SIZE;
         mode_ff  <= RST_MODE;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_ff <= csr_wdata[SRC_CFG_BITS-1:0];
            CSR_SOURCE_HEIGHT: src_h_ff <= csr_wdata[SRC_CFG_BITS-1:0];
            CSR_TARGET_WIDTH:  dst_w_ff <= csr_wdata[DST_BITS-1:0];
            CSR_TARGET_HEIGHT: dst_h_ff <= csr_wdata[DST_BITS-1:0];
            CSR_ROUNDING_MODE: mode_ff  <= csr_wdata[MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [SWM-1:0] bound_src(input logic [SRC_CFG_BITS-1:0] raw,
                                                input int max_size);
      logic [SWM-1:0] v;
      if (raw == '0) begin
         v = SWM'(1);
      end else if (int'(raw) > max_size) begin
         v = SWM'(max_size);
      end else begin
         v = SWM'(raw);
      end
      return v;
   endfunction

   function automatic logic [DST_BITS-1:0] bound_dst(input logic [DST_BITS-1:0] raw);
      return (raw == '0) ? DST_BITS'(1) : raw;
   endfunction

   // one restoring-division step: one quotient bit
   function automatic axis_type div_step(input axis_type a);
      axis_type       n;
      logic [RB-1:0]  r;
      n = a;
      r = {a.rem[RB-2:0], a.nq[DIV_BITS-1]};
      if (r >= {1'b0, a.dst}) begin
         n.rem = r - {1'b0, a.dst};
         n.nq  = {a.nq[DIV_BITS-2:0], 1'b1};
      end else begin
         n.rem = r;
         n.nq  = {a.nq[DIV_BITS-2:0], 1'b0};
      end
      return n;
   endfunction

   // round the finished quotient and clamp it to the source edge
   function automatic logic [SWM-1:0] round_clamp(input axis_type a,
                                                  input logic [MODE_BITS-1:0] mode);
      logic              inc;
      logic [DIV_BITS:0] q;
      logic [SWM-1:0]    lim;
      case (mode)
         RND_NEAREST: inc = ({a.rem, 1'b0} >= {2'b00, a.dst});
         RND_CEIL:    inc = (a.rem != '0);
         default:     inc = 1'b0;
      endcase
      q   = {1'b0, a.nq} + (DIV_BITS + 1)'(inc);
      lim = a.src - SWM'(1);
      return (q > (DIV_BITS + 1)'(lim)) ? lim : SWM'(q);
   endfunction

   logic [SWM-1:0]      sw_eff;
   logic [SWM-1:0]      sh_eff;
   logic                accept;
   logic                in_bounds;
   stage_type           pipe_in;
   stage_type           pipe_ff [0:DIV_BITS];
   stage_type           step_in [1:DIV_BITS];
   access_type          acc_in;
   access_type          acc_ff;
   logic [XW-1:0]       fx;
   logic [YW-1:0]       fy;

   assign sw_eff = bound_src(src_w_ff, MAX_SOURCE_WIDTH);
   assign sh_eff = bound_src(src_h_ff, MAX_SOURCE_HEIGHT);
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // entry stage: bounds check for loads, numerators for fetches
   always_comb begin
      in_bounds = (int'(req_word.coord_x) < int'(sw_eff)) &&
                  (int'(req_word.coord_y) < int'(sh_eff));
      pipe_in.vld  = accept && ((req_word.opcode == OP_FETCH) || in_bounds);
      pipe_in.op   = req_word.opcode;
      pipe_in.mode = mode_ff;
      pipe_in.pix  = req_word.pixel_in;
      pipe_in.addr = AB'(AB'(req_word.coord_y) * AB'(MAX_SOURCE_WIDTH)
                         + AB'(req_word.coord_x));
      pipe_in.ax_x.nq  = DIV_BITS'(DIV_BITS'(req_word.coord_x) * DIV_BITS'(sw_eff));
      pipe_in.ax_x.rem = '0;
      pipe_in.ax_x.dst = bound_dst(dst_w_ff);
      pipe_in.ax_x.src = sw_eff;
      pipe_in.ax_y.nq  = DIV_BITS'(DIV_BITS'(req_word.coord_y) * DIV_BITS'(sh_eff));
      pipe_in.ax_y.rem = '0;
      pipe_in.ax_y.dst = bound_dst(dst_h_ff);
      pipe_in.ax_y.src = sh_eff;
   end

   // divider stages; loads ride along so memory accesses stay in order
   always_comb begin
      for (int s = 0; s < DIV_BITS; s++) begin
         step_in[s+1]      = pipe_ff[s];
         step_in[s+1].ax_x = div_step(pipe_ff[s].ax_x);
         step_in[s+1].ax_y = div_step(pipe_ff[s].ax_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_BITS; s++) begin
            pipe_ff[s].vld <= 1'b0;
         end
      end else begin
         pipe_ff[0] <= pipe_in;
         for (int s = 1; s <= DIV_BITS; s++) begin
            pipe_ff[s] <= step_in[s];
         end
      end
   end

   always_comb begin
      fx = XW'(round_clamp(pipe_ff[DIV_BITS].ax_x, pipe_ff[DIV_BITS].mode));
      fy = YW'(round_clamp(pipe_ff[DIV_BITS].ax_y, pipe_ff[DIV_BITS].mode));
      acc_in.vld = pipe_ff[DIV_BITS].vld;
      acc_in.op  = pipe_ff[DIV_BITS].op;
      acc_in.pix = pipe_ff[DIV_BITS].pix;
      acc_in.mx  = fx;
      acc_in.my  = fy;
      if (pipe_ff[DIV_BITS].op == OP_LOAD) begin
         acc_in.addr = pipe_ff[DIV_BITS].addr;
      end else begin
         acc_in.addr = AB'(AB'(fy) * AB'(MAX_SOURCE_WIDTH) + AB'(fx));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff.vld <= 1'b0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // frame store: one access per cycle, write for loads, read for fetches
   logic [WORD_PIX_BITS-1:0] frame_mem [0:DEPTH-1];
   logic [WORD_PIX_BITS-1:0] rd_ff;
   logic [XW-1:0]            mx_ff;
   logic [YW-1:0]            my_ff;
   logic                     rsp_strobe_ff;
   logic                     rsp_strobe_in;

   assign rsp_strobe_in = acc_ff.vld && (acc_ff.op == OP_FETCH);

   always_ff @(posedge clock) begin
      if (acc_ff.vld && (acc_ff.op == OP_LOAD)) begin
         frame_mem[acc_ff.addr] <= acc_ff.pix;
      end
      rd_ff <= frame_mem[acc_ff.addr];
      mx_ff <= acc_ff.mx;
      my_ff <= acc_ff.my;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_word.pixel_out = rd_ff;
   assign rsp_word.mapped_x  = MAPPED_BITS'(mx_ff);
   assign rsp_word.mapped_y  = MAPPED_BITS'(my_ff);

endmodule

### sv/nnis_checker.sv
// Port-level checker for the nearest-neighbor image scaler, with its bind.
// Depends on nnis_pkg and the top level's port list.
module nnis_checker #(
   parameter int LATENCY = 22
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input nnis_pkg::req_type req_word,
   input logic              rsp_strobe
);
   import nnis_pkg::*;

   // every fetch word gets exactly one result after the fixed latency
   a_fetch_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.opcode == OP_FETCH) |-> ##LATENCY rsp_strobe)
      else $error("fetch word without a result");

   // a load word never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.opcode == OP_LOAD) |-> ##LATENCY !rsp_strobe)
      else $error("load word produced a result");

   // no result without a fetch accepted at the matching cycle
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_word.opcode == OP_FETCH, LATENCY))
      else $error("result without a fetch word");

   // nothing is held off: busy stays low after reset
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

bind nearest_neighbor_image_scaler nnis_checker #(
   .LATENCY(DIV_BITS + 3)
) u_nnis_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe)
);

### tb/tb_nearest_neighbor_image_scaler.sv
`timescale 1ns / 1ps
// Self-checking bench for nearest_neighbor_image_scaler: directed register and rounding
// tests, then randomized load/fetch traffic predicted by an in-bench frame copy.
// Depends on nnis_pkg and the scaler RTL only.
module tb_nearest_neighbor_image_scaler;
   import nnis_pkg::*;

   localparam int FRAME_COLS     = 64;
   localparam int FRAME_ROWS     = 64;
   localparam int FRAME_WORDS    = FRAME_COLS * FRAME_ROWS;
   localparam int FRAME_AB       = $clog2(FRAME_WORDS);
   localparam int TARGET_MAX     = 4095;
   localparam int ITEM_TARGET    = 1850;
   localparam int LATENCY_WAIT   = 40;
   localparam int DRAIN_LIMIT    = 4000;
   localparam int CYCLE_LIMIT    = 600000;

   // indexes past the last register
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_MID = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI  = 3'd7;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   req_type                   req_word;
   logic                      rsp_strobe;
   rsp_type                   rsp_word;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // mirror of the scaler's registers and frame store
   logic [SRC_CFG_BITS-1:0]   src_w_reg;
   logic [SRC_CFG_BITS-1:0]   src_h_reg;
   logic [DST_BITS-1:0]       dst_w_reg;
   logic [DST_BITS-1:0]       dst_h_reg;
   logic [MODE_BITS-1:0]      mode_reg;
   logic [WORD_PIX_BITS-1:0]  frame_copy [FRAME_WORDS];
   bit                        frame_written [FRAME_WORDS];

   rsp_type                   pending_pixels [$];
   int                        fail_count;
   int                        items_done;
   int                        fetch_count;
   int                        load_count;
   int                        ignored_count;
   int                        setting_count;
   int                        cycle_count = 0;

   nearest_neighbor_image_scaler DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_word     (req_word),
      .rsp_strobe   (rsp_strobe),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("nearest_neighbor_image_scaler verification failed");
         $finish;
      end
   end

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // exact c * src / dst with the configured rounding, clamped to the source edge
   function automatic int unsigned map_axis(int unsigned c, int unsigned src,
                                            int unsigned dst, logic [MODE_BITS-1:0] mode);
      int unsigned num;
      int unsigned q;
      int unsigned r;
      num = c * src;
      q = num / dst;
      r = num % dst;
      case (mode)
         RND_NEAREST: if (2 * r >= dst) q = q + 1;
         RND_CEIL:    if (r != 0) q = q + 1;
         default: ;
      endcase
      if (q > src - 1) q = src - 1;
      return q;
   endfunction

   function automatic logic [FRAME_AB-1:0] mapped_addr(int unsigned x, int unsigned y);
      int unsigned mx;
      int unsigned my;
      mx = map_axis(x, clamp_size(32'(src_w_reg), FRAME_COLS),
                    clamp_size(32'(dst_w_reg), TARGET_MAX), mode_reg);
      my = map_axis(y, clamp_size(32'(src_h_reg), FRAME_ROWS),
                    clamp_size(32'(dst_h_reg), TARGET_MAX), mode_reg);
      return FRAME_AB'(my * FRAME_COLS + mx);
   endfunction

   task automatic scale_lookup(req_type w);
      int unsigned         sw;
      int unsigned         sh;
      logic [FRAME_AB-1:0] addr;
      rsp_type             pix;
      sw = clamp_size(32'(src_w_reg), FRAME_COLS);
      sh = clamp_size(32'(src_h_reg), FRAME_ROWS);
      items_done++;
      if (w.opcode == OP_LOAD) begin
         if (32'(w.coord_x) < sw && 32'(w.coord_y) < sh) begin
            addr = FRAME_AB'(32'(w.coord_y) * FRAME_COLS + 32'(w.coord_x));
            frame_copy[addr] = w.pixel_in;
            frame_written[addr] = 1'b1;
            load_count++;
         end else begin
            ignored_count++;
         end
      end else begin
         addr = mapped_addr(32'(w.coord_x), 32'(w.coord_y));
         pix.pixel_out = frame_copy[addr];
         pix.mapped_x = MAPPED_BITS'(addr % FRAME_COLS);
         pix.mapped_y = MAPPED_BITS'(addr / FRAME_COLS);
         pending_pixels = {pending_pixels, pix};
         fetch_count++;
      end
   endtask

   task automatic apply_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_SOURCE_WIDTH:  src_w_reg = data[SRC_CFG_BITS-1:0];
         CSR_SOURCE_HEIGHT: src_h_reg = data[SRC_CFG_BITS-1:0];
         CSR_TARGET_WIDTH:  dst_w_reg = data[DST_BITS-1:0];
         CSR_TARGET_HEIGHT: dst_h_reg = data[DST_BITS-1:0];
         CSR_ROUNDING_MODE: mode_reg  = data[MODE_BITS-1:0];
         default: ;
      endcase
   endtask

   // leaves csr_write_en high; csr_done lowers it
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic program_scaler(int sw, int sh, int tw, int th, int mode);
      write_csr(CSR_SOURCE_WIDTH, CSR_DATA_BITS'(sw));
      write_csr(CSR_SOURCE_HEIGHT, CSR_DATA_BITS'(sh));
      write_csr(CSR_TARGET_WIDTH, CSR_DATA_BITS'(tw));
      write_csr(CSR_TARGET_HEIGHT, CSR_DATA_BITS'(th));
      write_csr(CSR_ROUNDING_MODE, CSR_DATA_BITS'(mode));
      csr_done();
      setting_count++;
   endtask

   // leaves start high so a burst runs back to back
   task automatic send_word(req_type w);
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      scale_lookup(w);
   endtask

   task automatic send_load(int unsigned x, int unsigned y, logic [WORD_PIX_BITS-1:0] pix);
      req_type w;
      w.opcode   = OP_LOAD;
      w.coord_x  = COORD_BITS'(x);
      w.coord_y  = COORD_BITS'(y);
      w.pixel_in = pix;
      send_word(w);
   endtask

   // store the mapped source pixel first if it was never written
   task automatic fetch_pixel(int unsigned x, int unsigned y);
      req_type             w;
      logic [FRAME_AB-1:0] addr;
      addr = mapped_addr(x, y);
      if (!frame_written[addr])
         send_load(addr % FRAME_COLS, addr / FRAME_COLS, $urandom());
      w.opcode   = OP_FETCH;
      w.coord_x  = COORD_BITS'(x);
      w.coord_y  = COORD_BITS'(y);
      w.pixel_in = $urandom();
      send_word(w);
   endtask

   task automatic hold_off(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // loads give no result, so wait out the pipeline before touching registers
   task automatic settle();
      drain_results();
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            $error("result word with nothing pending: %h", rsp_word);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_word.pixel_out !== want.pixel_out) begin
               $error("pixel_out expected %h actual %h", want.pixel_out, rsp_word.pixel_out);
               fail_count++;
            end
            if (rsp_word.mapped_x !== want.mapped_x) begin
               $error("mapped_x expected %0d actual %0d", want.mapped_x, rsp_word.mapped_x);
               fail_count++;
            end
            if (rsp_word.mapped_y !== want.mapped_y) begin
               $error("mapped_y expected %0d actual %0d", want.mapped_y, rsp_word.mapped_y);
               fail_count++;
            end
         end
      end
   end

   // reset values, pixel extremes, ignored loads, fetch past the destination
   task automatic test_reset_defaults();
      send_load(0, 0, 32'hFFFF_FFFF);
      send_load(FRAME_COLS - 1, FRAME_ROWS - 1, 32'h0000_0000);
      send_load(FRAME_COLS, 0, 32'hA5A5_5A5A);
      send_load(0, TARGET_MAX, 32'h5A5A_A5A5);
      fetch_pixel(0, 0);
      fetch_pixel(FRAME_COLS - 1, FRAME_ROWS - 1);
      fetch_pixel(TARGET_MAX, TARGET_MAX);
   endtask

   // 1 * 3 / 2 and 1 * 5 / 2 land on a half: each mode resolves the tie its own way
   task automatic test_rounding_modes();
      for (int m = 0; m < 4; m++) begin
         settle();
         program_scaler(3, 5, 2, 2, m);
         fetch_pixel(1, 1);
         fetch_pixel(2, 3);
      end
   endtask

   // zero and oversize sizes, data bits above a register's width, unused indexes
   task automatic test_register_edges();
      settle();
      program_scaler(0, 127, 0, TARGET_MAX, int'(RND_CEIL));
      write_csr(CSR_SPARE_LO, 12'hFFF);
      write_csr(CSR_SPARE_MID, 12'h001);
      write_csr(CSR_SPARE_HI, 12'h800);
      csr_done();
      fetch_pixel(TARGET_MAX, TARGET_MAX);
      fetch_pixel(0, 1);
      settle();
      program_scaler('hF81, 'hFC0, 1, 1, 'hFFE);
      send_load(1, 0, $urandom());
      fetch_pixel('hABC, 'h543);
   endtask

   function automatic int unsigned pick_coord(int unsigned dst);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return $urandom_range(dst - 1, 0);
      if (roll < 9) return $urandom_range(TARGET_MAX, dst);
      return $urandom_range(TARGET_MAX, 0);
   endfunction

   function automatic int unsigned pick_source(int unsigned hi);
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 5) return hi;
      if (roll < 7) return 1;
      if (roll < 8) return $urandom_range(0, 1) ? 0 : $urandom_range(127, hi + 1);
      return $urandom_range(hi, 1);
   endfunction

   function automatic int unsigned pick_target();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 2) return TARGET_MAX;
      if (roll < 4) return 1;
      if (roll < 5) return 0;
      if (roll < 13) return $urandom_range(128, 1);
      return $urandom_range(TARGET_MAX, 1);
   endfunction

   task automatic send_random_item();
      int unsigned sw;
      int unsigned sh;
      sw = clamp_size(32'(src_w_reg), FRAME_COLS);
      sh = clamp_size(32'(src_h_reg), FRAME_ROWS);
      if ($urandom_range(0, 9) < 4) begin
         if ($urandom_range(0, 9) < 8)
            send_load($urandom_range(sw - 1, 0), $urandom_range(sh - 1, 0), $urandom());
         else
            send_load($urandom_range(TARGET_MAX, 0), $urandom_range(TARGET_MAX, 0), $urandom());
      end else begin
         fetch_pixel(pick_coord(clamp_size(32'(dst_w_reg), TARGET_MAX)),
                     pick_coord(clamp_size(32'(dst_h_reg), TARGET_MAX)));
      end
   endtask

   task automatic run_phase(int count);
      int target;
      int pause_at;
      int burst;
      bit paused;
      target = items_done + count;
      pause_at = items_done + $urandom_range(count - 1, 0);
      paused = 1'b0;
      while (items_done < target) begin
         burst = $urandom_range(40, 1);
         while (burst > 0 && items_done < target) begin
            send_random_item();
            burst--;
         end
         if (!paused && items_done >= pause_at) begin
            drain_results();
            paused = 1'b1;
         end else if ($urandom_range(0, 9) >= 3) begin
            hold_off($urandom_range(8, 1));
         end
      end
   endtask

   task automatic test_random_scaling();
      int phase;
      int count;
      phase = 0;
      while (items_done < ITEM_TARGET) begin
         settle();
         case (phase)
            0: program_scaler(FRAME_COLS, FRAME_ROWS, TARGET_MAX, TARGET_MAX, $urandom_range(3, 0));
            1: program_scaler(1, 1, 1, 1, $urandom_range(3, 0));
            2: program_scaler(FRAME_COLS, FRAME_ROWS, 1, 1, int'(RND_CEIL));
            default: program_scaler(pick_source(FRAME_COLS), pick_source(FRAME_ROWS),
                                    pick_target(), pick_target(), $urandom_range(3, 0));
         endcase
         count = $urandom_range(300, 150);
         if (count > ITEM_TARGET - items_done) count = ITEM_TARGET - items_done;
         run_phase(count);
         phase++;
      end
   endtask

   initial begin
      int waited;
      reset         = 1'b1;
      start         = 1'b0;
      req_word      = '0;
      csr_write_en  = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      src_w_reg     = RST_SOURCE_SIZE;
      src_h_reg     = RST_SOURCE_SIZE;
      dst_w_reg     = RST_TARGET_SIZE;
      dst_h_reg     = RST_TARGET_SIZE;
      mode_reg      = RST_MODE;
      fail_count    = 0;
      items_done    = 0;
      fetch_count   = 0;
      load_count    = 0;
      ignored_count = 0;
      setting_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_rounding_modes();
      test_register_edges();
      test_random_scaling();

      @(negedge clock);
      start <= 1'b0;
      waited = 0;
      while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY_WAIT) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         $error("%0d fetch results never arrived", pending_pixels.size());
         fail_count++;
      end
      $display("Run covered %0d fetches and %0d stored loads (%0d out-of-source loads dropped)",
               fetch_count, load_count, ignored_count);
      $display("across %0d scaler settings, all four rounding codes, in %0d cycles",
               setting_count, cycle_count);
      if (fail_count == 0)
         $display("nearest_neighbor_image_scaler verification clean");
      else
         $display("nearest_neighbor_image_scaler verification failed");
      $finish;
   end

endmodule

### filelist.f
sv/nnis_pkg.sv
sv/nearest_neighbor_image_scaler.sv
sv/nnis_checker.sv
tb/tb_nearest_neighbor_image_scaler.sv
